// ===== rtl/core/fttl_pkg.sv =====
// ----------------------------------------------------------------------------
// fttl_pkg: shared types and constants for the TTL key cache
// Holds the entry count, field widths, operation and status codes.
// ----------------------------------------------------------------------------
package fttl_pkg;

    localparam int ENTRIES = 16;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [2:0] {
        OP_GET      = 3'd0,
        OP_PUT      = 3'd1,
        OP_LOAD     = 3'd2,
        OP_SNAPSHOT = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    localparam logic [1:0] ST_MISS   = 2'd0;
    localparam logic [1:0] ST_HIT    = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_SNAP   = 2'd3;

    localparam logic [0:0] CFG_CAPACITY = 1'b0;
    localparam logic [0:0] CFG_TTL      = 1'b1;

    // One stored entry.
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] handle;
        logic [31:0] stamp;
    } entry_t;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic        shift;     // compact: take neighbor's entry if at or above hole
        logic        clear;     // drop all entries
        logic        write;     // write the target cell; beats a shift in that cell
        logic        rotate;    // snapshot: move every entry one place toward head
        entry_t      wdata;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EVICT,
        S_SNAP,
        S_OUT
    } state_t;

endpackage

// ===== rtl/core/fifo_ttl_key_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_ttl_key_cache: keyed fingerprint cache with FIFO replacement and TTL
// Entries sit in a chain of cells ordered oldest first; holes are closed by
// shifting one place per cycle.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid/in_ready, operation ... now      | in
//  result  | out_valid/out_ready, status ... last      | out
//  config  | cfg_we, cfg_index, cfg_wdata              | in
//
// Get, put, load and clear pass from one acceptance to the next through
// capture, execute with a key compare across all cells, and hand-over.
// An expired get entry or the drop of the oldest on a full table is closed
// in the execute cycle; the evict state then drops one entry per step
// down to the capacity. Snapshot steps through the held entries one by one,
// then closes, with a hand-over when nothing is listed. A waiting result
// word stalls the hand-over and every snapshot step. Reset empties the table.
module fifo_ttl_key_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [63:0] lookup_key,
    input  logic [31:0] response_handle,
    input  logic [31:0] stamp_seconds,
    input  logic [31:0] now_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] found_key,
    output logic [31:0] found_handle,
    output logic [31:0] found_stamp,
    output logic [4:0]  entry_count,
    output logic        last,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import fttl_pkg::*;

    // Configuration.
    logic [4:0]  cap_reg;
    logic [31:0] ttl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 5'd16;
            ttl_reg <= 32'd3600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg <= cfg_wdata[4:0];
                CFG_TTL:      ttl_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Request latch.
    logic [2:0]  op_reg;
    logic [63:0] key_reg;
    logic [31:0] hdl_reg, stp_reg, now_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] snap_reg, snap_next;   // rotations left
    logic             any_reg, any_next;     // snapshot emitted something

    // Result of the current request, waiting for the output register.
    logic [1:0]  res_st_reg, res_st_next;
    logic [31:0] res_hdl_reg, res_hdl_next;
    logic [31:0] res_stp_reg, res_stp_next;

    // Output register.
    logic             ov_reg, ov_next;
    logic [1:0]       st_reg, st_next;
    logic [63:0]      ok_reg, ok_next;
    logic [31:0]      oh_reg, oh_next;
    logic [31:0]      os_reg, os_next;
    logic             ol_reg, ol_next;
    logic [CNT_W-1:0] oc_reg, oc_next;

    // Cell chain.
    cell_cmd_t        cmd;
    entry_t           ents [ENTRIES];
    entry_t           uppers [ENTRIES];
    logic [ENTRIES-1:0] match, kill, move_up, wsel;
    logic [IDX_W-1:0] hole;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == ENTRIES - 1)
            begin : g_top
                assign uppers[g] = (cmd.rotate) ? ents[0] : '0;
            end
            else
            begin : g_mid
                assign uppers[g] = ents[g+1];
            end
            assign move_up[g] = (IDX_W'(g) >= hole);
            fttl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .kill    (kill[g]),
                .move_up (move_up[g]),
                .wsel    (wsel[g]),
                .upper   (uppers[g]),
                .req_key (key_reg),
                .ent     (ents[g]),
                .match   (match[g])
            );
        end
    endgenerate

    // Hit position among cells (at most one matches).
    logic [IDX_W-1:0] hit_idx;
    logic             hit;
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end
    assign hit = |match;

    function automatic logic expired(input logic [31:0] s, input logic [31:0] n,
                                     input logic [31:0] t);
        return (n > s) && ((n - s) > t);
    endfunction

    logic hit_stale, hit_live;
    assign hit_stale = hit && expired(ents[hit_idx].stamp, now_reg, ttl_reg);
    assign hit_live  = hit && !expired(ents[hit_idx].stamp, now_reg, ttl_reg);

    logic [4:0] cap_eff;
    assign cap_eff = (cap_reg > 5'(ENTRIES)) ? 5'(ENTRIES) : cap_reg;

    logic load_ok;
    assign load_ok = (hdl_reg != 32'd0) && (stp_reg <= now_reg)
                     && ((now_reg - stp_reg) <= ttl_reg);

    logic [31:0] put_stamp;
    assign put_stamp = (op_reg == OP_LOAD) ? stp_reg : now_reg;

    logic out_free;
    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            S_EXEC:
                priority if (op_reg == OP_SNAPSHOT)
                begin
                    state_next = S_SNAP;
                end
                else if (((op_reg == OP_PUT) || (op_reg == OP_LOAD && load_ok))
                         && (cnt_next > CNT_W'(cap_eff)))
                begin
                    state_next = S_EVICT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            S_EVICT:
                if (cnt_next <= CNT_W'(cap_eff))
                begin
                    state_next = S_OUT;
                end
            S_SNAP:
                if (out_free && snap_reg == '0)
                begin
                    state_next = (any_reg) ? S_IDLE : S_OUT;
                end
            S_OUT:
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    // Cell commands and counters.
    always_comb
    begin
        cmd       = '0;
        kill      = '0;
        wsel      = '0;
        hole      = IDX_W'(ENTRIES - 1);
        cnt_next  = cnt_reg;
        snap_next = snap_reg;
        any_next  = any_reg;
        cmd.wdata = '{valid: 1'b1, key: key_reg, handle: hdl_reg, stamp: put_stamp};
        unique case (state_reg)
            S_EXEC:
                unique case (op_reg)
                    OP_GET:
                        if (hit_stale)
                        begin
                            cmd.shift = 1'b1;
                            hole      = hit_idx;
                            cnt_next  = cnt_reg - CNT_W'(1);
                        end
                    OP_PUT, OP_LOAD:
                        if (op_reg == OP_PUT || load_ok)
                        begin
                            cmd.write = 1'b1;
                            if (hit)
                            begin
                                wsel[hit_idx] = 1'b1;
                            end
                            else if (cnt_reg >= CNT_W'(ENTRIES))
                            begin
                                // Full: drop the oldest and append at the top.
                                cmd.shift = 1'b1;
                                hole      = '0;
                                wsel[ENTRIES-1] = 1'b1;
                            end
                            else
                            begin
                                wsel[cnt_reg[IDX_W-1:0]] = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    OP_SNAPSHOT:
                    begin
                        snap_next = cnt_reg;
                        any_next  = 1'b0;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                        cnt_next  = '0;
                    end
                    default: ;
                endcase
            S_EVICT:
                if (cnt_reg > CNT_W'(cap_eff))
                begin
                    cmd.shift = 1'b1;
                    hole      = '0;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            S_SNAP:
                if (out_free && snap_reg != '0)
                begin
                    // Rotate only over the held entries: when all cells are held, the top cell takes cell 0.
                    cmd.rotate = (cnt_reg == CNT_W'(ENTRIES));
                    if (cnt_reg != CNT_W'(ENTRIES))
                    begin
                        // Partial chain: move head to position cnt-1.
                        cmd.shift = 1'b1;
                        hole      = '0;
                        cmd.write = 1'b1;
                        cmd.wdata = ents[0];
                        wsel[IDX_W'(cnt_reg - CNT_W'(1))] = 1'b1;
                    end
                    snap_next = snap_reg - CNT_W'(1);
                    if (!expired(ents[0].stamp, now_reg, ttl_reg))
                    begin
                        any_next = 1'b1;
                    end
                end
            default: ;
        endcase
    end

    // Inside a cell a write beats a shift, so the write target keeps the new
    // entry while the rest of the chain moves down past it.

    // Snapshot word is the last one when no live entry remains behind it.
    logic snap_last;
    always_comb
    begin
        snap_last = 1'b1;
        for (int i = 1; i < ENTRIES; i++)
        begin
            if (CNT_W'(i) < snap_reg && !expired(ents[i].stamp, now_reg, ttl_reg))
            begin
                snap_last = 1'b0;
            end
        end
    end

    // Result of a single-word request, settled in the execute cycle.
    always_comb
    begin
        res_st_next  = res_st_reg;
        res_hdl_next = res_hdl_reg;
        res_stp_next = res_stp_reg;
        if (state_reg == S_EXEC)
        begin
            res_st_next  = ST_MISS;
            res_hdl_next = '0;
            res_stp_next = '0;
            unique case (op_reg)
                OP_GET:
                    if (hit_live)
                    begin
                        res_st_next  = ST_HIT;
                        res_hdl_next = ents[hit_idx].handle;
                        res_stp_next = ents[hit_idx].stamp;
                    end
                OP_PUT:
                begin
                    res_st_next  = ST_HIT;
                    res_stp_next = now_reg;
                end
                OP_LOAD:
                    if (load_ok)
                    begin
                        res_st_next  = ST_HIT;
                        res_stp_next = stp_reg;
                    end
                    else
                    begin
                        res_st_next = ST_REJECT;
                    end
                default: ;
            endcase
        end
    end

    // Output register: loaded when free, cleared when the word is taken.
    always_comb
    begin
        ov_next = ov_reg && !out_ready;
        st_next = st_reg;
        ok_next = ok_reg;
        oh_next = oh_reg;
        os_next = os_reg;
        ol_next = ol_reg;
        oc_next = oc_reg;
        if (state_reg == S_OUT && out_free)
        begin
            ov_next = 1'b1;
            st_next = res_st_reg;
            ok_next = key_reg;
            oh_next = res_hdl_reg;
            os_next = res_stp_reg;
            ol_next = 1'b1;
            oc_next = cnt_reg;
        end
        else if (state_reg == S_SNAP && out_free && snap_reg != '0)
        begin
            ov_next = !expired(ents[0].stamp, now_reg, ttl_reg);
            st_next = ST_SNAP;
            ok_next = ents[0].key;
            oh_next = ents[0].handle;
            os_next = ents[0].stamp;
            ol_next = snap_last;
            oc_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            snap_reg  <= '0;
            any_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            snap_reg  <= snap_next;
            any_reg   <= any_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg  <= operation;
            key_reg <= lookup_key;
            hdl_reg <= response_handle;
            stp_reg <= stamp_seconds;
            now_reg <= now_seconds;
        end
        res_st_reg  <= res_st_next;
        res_hdl_reg <= res_hdl_next;
        res_stp_reg <= res_stp_next;
        st_reg      <= st_next;
        ok_reg      <= ok_next;
        oh_reg      <= oh_next;
        os_reg      <= os_next;
        ol_reg      <= ol_next;
        oc_reg      <= oc_next;
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign found_key    = ok_reg;
    assign found_handle = oh_reg;
    assign found_stamp  = os_reg;
    assign entry_count  = oc_reg;
    assign last         = ol_reg;

endmodule

// ===== rtl/core/fttl_cell.sv =====
// ----------------------------------------------------------------------------
// fttl_cell: one slot of the age-ordered entry chain
// Cell 0 is the oldest. A cell compares its key and may take the entry of
// its upper neighbor when a hole at or below it closes, or when the chain rotates.
// A write aimed at this cell takes precedence over a shift.
// ----------------------------------------------------------------------------
module fttl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  fttl_pkg::cell_cmd_t cmd,
    input  logic               kill,      // this cell's entry is removed
    input  logic               move_up,   // hole at or below: take neighbor
    input  logic               wsel,      // this cell is the write target
    input  fttl_pkg::entry_t   upper,     // entry of neighbor above
    input  logic [63:0]        req_key,
    output fttl_pkg::entry_t   ent,
    output logic               match
);
    import fttl_pkg::*;

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;

    assign ent   = '{valid: valid_reg, key: data_reg.key, handle: data_reg.handle,
                     stamp: data_reg.stamp};
    assign match = valid_reg && (data_reg.key == req_key);

    // Next entry of this slot.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.write && wsel)
        begin
            valid_next = 1'b1;
            data_next  = cmd.wdata;
        end
        else if (cmd.rotate || (cmd.shift && move_up))
        begin
            valid_next = upper.valid;
            data_next  = upper;
        end
        else if (kill)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== test/tb_fifo_ttl_key_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_ttl_key_cache: self-checking bench for the TTL key cache
// Drives get, put, load, snapshot, clear and undefined operation words with random gaps on both
// channels, predicts every result word from a software table kept in
// insertion order, and compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_fifo_ttl_key_cache;
    import fttl_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  operation;
    logic [63:0] lookup_key;
    logic [31:0] response_handle;
    logic [31:0] stamp_seconds;
    logic [31:0] now_seconds;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] found_key;
    logic [31:0] found_handle;
    logic [31:0] found_stamp;
    logic [4:0]  entry_count;
    logic        last;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] key;
        logic [31:0] handle;
        logic [31:0] stamp;
        logic [4:0]  count;
        logic        last;
    } result_t;

    // Predicted table, kept oldest first.
    logic [63:0] tbl_key[$];
    logic [31:0] tbl_handle[$];
    logic [31:0] tbl_stamp[$];
    logic [4:0]  cap_reg;
    logic [31:0] ttl_reg;
    logic [31:0] clock_now;

    result_t     pending_results[$];
    int          mismatch_count;
    int          idle_cycles;
    int          rx_wait = 0;
    bit          rx_hold;
    logic [63:0] used_keys[$];

    fifo_ttl_key_cache uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit aged_out(logic [31:0] stamp, logic [31:0] now);
        return (now > stamp) && ((now - stamp) > ttl_reg);
    endfunction

    function automatic int locate(logic [63:0] key);
        foreach (tbl_key[i])
            if (tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int idx);
        tbl_key.delete(idx);
        tbl_handle.delete(idx);
        tbl_stamp.delete(idx);
    endfunction

    function automatic void queue_word(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void store_entry(logic [63:0] key, logic [31:0] handle,
                                        logic [31:0] stamp);
        int idx;
        int lim;
        idx = locate(key);
        if (idx >= 0)
        begin
            tbl_handle[idx] = handle;
            tbl_stamp[idx] = stamp;
        end
        else
        begin
            tbl_key.insert(tbl_key.size(), key);
            tbl_handle.insert(tbl_handle.size(), handle);
            tbl_stamp.insert(tbl_stamp.size(), stamp);
        end
        lim = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
        while (tbl_key.size() > lim)
            drop_entry(0);
    endfunction

    function automatic result_t make_word(logic [1:0] st, logic [63:0] key,
                                          logic [31:0] handle, logic [31:0] stamp);
        result_t r;
        r.status = st;
        r.key = key;
        r.handle = handle;
        r.stamp = stamp;
        r.count = 5'(tbl_key.size());
        r.last = 1'b1;
        return r;
    endfunction

    // Apply one request word to the predicted table and queue its results.
    function automatic void predict_cache(logic [2:0] op, logic [63:0] key,
                                          logic [31:0] handle, logic [31:0] stamp,
                                          logic [31:0] now);
        int idx;
        int n;
        result_t r;
        case (op)
            OP_GET:
            begin
                idx = locate(key);
                if (idx < 0)
                    queue_word(make_word(ST_MISS, key, 0, 0));
                else if (aged_out(tbl_stamp[idx], now))
                begin
                    drop_entry(idx);
                    queue_word(make_word(ST_MISS, key, 0, 0));
                end
                else
                    queue_word(make_word(ST_HIT, key, tbl_handle[idx], tbl_stamp[idx]));
            end
            OP_PUT:
            begin
                store_entry(key, handle, now);
                queue_word(make_word(ST_HIT, key, 0, now));
            end
            OP_LOAD:
            begin
                if (handle == 0 || stamp > now || (now - stamp) > ttl_reg)
                    queue_word(make_word(ST_REJECT, key, 0, 0));
                else
                begin
                    store_entry(key, handle, stamp);
                    queue_word(make_word(ST_HIT, key, 0, stamp));
                end
            end
            OP_SNAPSHOT:
            begin
                n = 0;
                foreach (tbl_key[i])
                begin
                    if (!aged_out(tbl_stamp[i], now))
                    begin
                        r = make_word(ST_SNAP, tbl_key[i], tbl_handle[i], tbl_stamp[i]);
                        r.last = 1'b0;
                        queue_word(r);
                        n++;
                    end
                end
                if (n == 0)
                    queue_word(make_word(ST_MISS, key, 0, 0));
                else
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            OP_CLEAR:
            begin
                tbl_key.delete();
                tbl_handle.delete();
                tbl_stamp.delete();
                queue_word(make_word(ST_MISS, key, 0, 0));
            end
            default:
                queue_word(make_word(ST_MISS, key, 0, 0));
        endcase
    endfunction

    // Random gap: mostly short, sometimes long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        else if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one request word and predict its results at acceptance. Valid stays
    // high after acceptance so that the next word can follow without a gap.
    task automatic send_word(logic [2:0] op, logic [63:0] key, logic [31:0] handle,
                             logic [31:0] stamp, logic [31:0] now);
        operation <= op;
        lookup_key <= key;
        response_handle <= handle;
        stamp_seconds <= stamp;
        now_seconds <= now;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_cache(op, key, handle, stamp, now);
    endtask

    task automatic send_gapped(logic [2:0] op, logic [63:0] key, logic [31:0] handle,
                               logic [31:0] stamp, logic [31:0] now);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        send_word(op, key, handle, stamp, now);
    endtask

    // Wait until every predicted word has arrived, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CAPACITY)
            cap_reg = value[4:0];
        else
            ttl_reg = value;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic void fill_keys(int n);
        used_keys.delete();
        repeat (n) used_keys.insert(used_keys.size(), {$urandom, $urandom});
    endfunction

    // Extremes of the fields, each operation and the named corner cases.
    task automatic test_directed();
        send_word(OP_SNAPSHOT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send_word(OP_GET, 64'h0, 0, 0, 0);
        send_word(OP_PUT, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
        send_word(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 0, 100);
        send_word(OP_GET, 64'h0, 0, 0, 200);
        send_word(OP_PUT, 64'h0, 32'h1234, 0, 300);
        send_word(OP_LOAD, 64'h55, 0, 300, 300);
        send_word(OP_LOAD, 64'h55, 7, 301, 300);
        send_word(OP_LOAD, 64'h55, 7, 0, 3601);
        send_word(OP_LOAD, 64'h55, 7, 1, 3601);
        send_word(OP_SNAPSHOT, 64'hA5, 0, 0, 3601);
        send_word(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 3701);
        send_word(OP_GET, 64'h0, 0, 0, 3900);
        send_word(OP_GET, 64'h55, 0, 0, 3901);
        send_word(3'd5, 64'h77, 1, 1, 3901);
        send_word(3'd7, 64'h77, 1, 1, 3901);
        send_word(3'd6, 64'h77, 1, 1, 3901);
        send_word(OP_CLEAR, 64'hC1, 0, 0, 3901);
        send_word(OP_SNAPSHOT, 64'hC2, 0, 0, 32'hFFFF_FFFF);
        // A stamp after now counts as age zero.
        send_word(OP_PUT, 64'h99, 5, 0, 32'hFFFF_FFFF);
        send_word(OP_GET, 64'h99, 0, 0, 32'hFFFF_FFFF);
        drain();
    endtask

    // Fill past the capacity, then lower it and watch the next store evict.
    task automatic test_capacity();
        write_reg(CFG_CAPACITY, 5'd16);
        write_reg(CFG_TTL, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 18; i++)
            send_gapped(OP_PUT, 64'h1000 + i, i + 1, 0, i);
        send_word(OP_SNAPSHOT, 1, 0, 0, 50);
        drain();
        write_reg(CFG_CAPACITY, 5'd3);
        send_word(OP_SNAPSHOT, 2, 0, 0, 50);
        send_word(OP_LOAD, 64'h2000, 9, 10, 50);
        send_word(OP_SNAPSHOT, 3, 0, 0, 50);
        drain();
        write_reg(CFG_CAPACITY, 5'd0);
        send_word(OP_PUT, 64'h3000, 1, 0, 60);
        send_word(OP_SNAPSHOT, 4, 0, 0, 60);
        drain();
        write_reg(CFG_CAPACITY, 5'd31);
        for (int i = 0; i < 17; i++)
            send_gapped(OP_PUT, 64'h4000 + i, i, 0, 70);
        send_word(OP_SNAPSHOT, 5, 0, 0, 70);
        drain();
    endtask

    // Hold the result side off while requests keep arriving.
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_word(OP_PUT, 64'h5000 + i, i + 1, 0, 80);
                send_word(OP_SNAPSHOT, 6, 0, 0, 80);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        join
        drain();
    endtask

    // Random traffic on a small key set, over several register settings.
    task automatic test_random(int ttl, int cap, int n);
        logic [2:0]  op;
        logic [63:0] key;
        logic [31:0] handle;
        logic [31:0] stamp;
        int p;
        write_reg(CFG_TTL, ttl);
        write_reg(CFG_CAPACITY, cap);
        fill_keys($urandom_range(4, 24));
        repeat (n)
        begin
            p = $urandom_range(0, 99);
            op = (p < 30) ? OP_GET : (p < 60) ? OP_PUT : (p < 82) ? OP_LOAD :
                 (p < 92) ? OP_SNAPSHOT : (p < 96) ? OP_CLEAR : 3'($urandom_range(5, 7));
            key = pick_key();
            handle = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
            if (clock_now > 32'hFFFF_0000)
                clock_now = 0;
            clock_now = clock_now + $urandom_range(0, ttl / 3 + 2);
            p = $urandom_range(0, 9);
            stamp = (p == 0) ? clock_now + $urandom_range(1, 5) :
                    (p == 1) ? $urandom : clock_now - $urandom_range(0, ttl + 2);
            send_gapped(op, key, handle, stamp, clock_now);
        end
        drain();
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status, found_key, found_handle, found_stamp, entry_count, last};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Result side: random stalls of random length, plus a long hold when asked.
    always @(posedge clk)
    begin
        if (!rst_n || rx_hold)
            out_ready <= 1'b0;
        else if (rx_wait != 0)
        begin
            out_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            out_ready <= 1'b0;
            rx_wait <= gap_len();
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_fifo_ttl_key_cache: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = '0;
        lookup_key = '0;
        response_handle = '0;
        stamp_seconds = '0;
        now_seconds = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rx_hold = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        cap_reg = 5'd16;
        ttl_reg = 32'd3600;
        clock_now = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random(3600, 16, 90);
        test_random(40, 6, 100);
        test_random(0, 1, 40);
        test_random(32'hFFFF_FFFF, 31, 80);
        test_random(500, 0, 30);
        drain();
        if (mismatch_count == 0)
            $display("tb_fifo_ttl_key_cache: done, clean");
        else
            $display("tb_fifo_ttl_key_cache: done, errors");
        $finish;
    end

endmodule
